### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is low.
`define MTW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge, off while reset is low.
`define MTW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/mtw_pkg.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog package
// Sizes, command and status codes, and table access types.
// ----------------------------------------------------------------------------
package mtw_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CMD_W   = 3;
  localparam int ID_W    = 8;
  localparam int MS_W    = 32;
  localparam int PER_W   = 16;
  localparam int STAT_W  = 2;
  localparam int WCNT_W  = 5;

  localparam logic [PER_W-1:0] PERIOD_RESET = 16'd1000;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // Write request into the entry table.
  typedef struct packed {
    logic             we_key;   // write id and timeout
    logic             we_seen;  // write last-seen time
    logic [IDX_W-1:0] addr;
    logic [ID_W-1:0]  id;
    logic [MS_W-1:0]  tmo;
    logic [MS_W-1:0]  seen;
  } tbl_wr_t;

  // One table entry as read back.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] tmo;
    logic [MS_W-1:0] seen;
  } tbl_rd_t;

endpackage

### sv/multi_task_watchdog.sv
// Sequence: tick without scan, suspend, spare codes and add with zero timeout go
//   straight to the response; scan and lookup walk up to the N table entries,
//   start fills them, and remove walks then compacts (compaction overlaps).
// Throughput: one command at a time; the next input is taken the cycle after the
//   result loads, and a stalled result holds the sequencer in its response state.
// Reset: asynchronous active low; clears clock, period counter, flags and count.
// ----------------------------------------------------------------------------
// Multi-task watchdog
// Table of watched tasks with periodic silence scan and fault latch.
// ----------------------------------------------------------------------------
module multi_task_watchdog (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel: check period in ticks
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mtw_pkg::PER_W-1:0]   check_period_ms_i,
  // command channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mtw_pkg::CMD_W-1:0]   cmd_i,
  input  logic [mtw_pkg::ID_W-1:0]    task_id_i,
  input  logic [mtw_pkg::MS_W-1:0]    timeout_ms_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mtw_pkg::STAT_W-1:0]  status_o,
  output logic                        restart_o,
  output logic [mtw_pkg::ID_W-1:0]    fault_task_o,
  output logic [mtw_pkg::MS_W-1:0]    silence_ms_o,
  output logic [mtw_pkg::WCNT_W-1:0]  watched_count_o
);

  // Sequencer states. SCAN serves both the periodic silence scan (tick) and
  // the id lookup (add, remove, kick); which compare applies follows cmd_q.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MOVE = 5'b00100,
    S_FILL = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Command held for the duration of the walk.
  logic [mtw_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [mtw_pkg::ID_W-1:0]  id_q, id_d;
  logic [mtw_pkg::MS_W-1:0]  tmo_q, tmo_d;

  // Watchdog state.
  logic [mtw_pkg::PER_W-1:0] period_q, period_d;
  logic [mtw_pkg::MS_W-1:0]  clock_q, clock_d;
  logic [mtw_pkg::PER_W-1:0] pcount_q, pcount_d;
  logic [mtw_pkg::PER_W-1:0] pcount_inc;
  logic                      watch_q, watch_d;
  logic                      fault_q, fault_d;
  logic [mtw_pkg::CNT_W-1:0] count_q, count_d;

  // Walk control: ptr_q is the next entry to read, rv_q marks read data
  // coming back this cycle for entry ridx_q.
  logic [mtw_pkg::CNT_W-1:0] ptr_q, ptr_d;
  logic                      rv_q, rv_d;
  logic [mtw_pkg::IDX_W-1:0] ridx_q, ridx_d;

  // Result being built.
  logic [mtw_pkg::STAT_W-1:0] pst_q, pst_d;
  logic                       prs_q, prs_d;
  logic [mtw_pkg::ID_W-1:0]   ptask_q, ptask_d;
  logic [mtw_pkg::MS_W-1:0]   psil_q, psil_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;
  logic [mtw_pkg::STAT_W-1:0]  status_q;
  logic                        restart_q;
  logic [mtw_pkg::ID_W-1:0]    fault_task_q;
  logic [mtw_pkg::MS_W-1:0]    silence_q;
  logic [mtw_pkg::WCNT_W-1:0]  wcount_q;

  // Table access.
  mtw_pkg::tbl_wr_t          tbl_wr;
  mtw_pkg::tbl_rd_t          tbl_rd;
  logic                      rd_en;
  logic [mtw_pkg::IDX_W-1:0] rd_addr;

  logic [mtw_pkg::MS_W-1:0]  silence;
  logic                      hit;
  logic                      walk_more;

  mtw_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_o      (tbl_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Wrap-safe silence of the entry coming back from the table.
  assign silence    = clock_q - tbl_rd.seen;
  assign hit        = (cmd_q == mtw_pkg::CMD_TICK) ? (silence > tbl_rd.tmo)
                                                   : (tbl_rd.id == id_q);
  assign walk_more  = (ptr_q < count_q);
  assign pcount_inc = pcount_q + 1'b1;
  assign rd_addr    = ptr_q[mtw_pkg::IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    tmo_d       = tmo_q;
    period_d    = period_q;
    clock_d     = clock_q;
    pcount_d    = pcount_q;
    watch_d     = watch_q;
    fault_d     = fault_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rv_d        = 1'b0;
    ridx_d      = ridx_q;
    pst_d       = pst_q;
    prs_d       = prs_q;
    ptask_d     = ptask_q;
    psil_d      = psil_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    tbl_wr      = '0;

    if (cfg_valid_i) begin
      period_d = check_period_ms_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          id_d    = task_id_i;
          tmo_d   = timeout_ms_i;
          pst_d   = mtw_pkg::ST_DONE;
          prs_d   = 1'b0;
          ptask_d = '0;
          psil_d  = '0;
          ptr_d   = '0;
          state_d = S_RESP;
          case (cmd_i)
            mtw_pkg::CMD_TICK: begin
              clock_d = clock_q + 1'b1;
              // Period hit uses >= so a zero period scans on every tick.
              if (pcount_inc >= period_q) begin
                pcount_d = '0;
                if (watch_q && !fault_q) begin
                  state_d = S_SCAN;
                end
              end else begin
                pcount_d = pcount_inc;
              end
            end
            mtw_pkg::CMD_ADD: begin
              if (timeout_ms_i == '0) begin
                pst_d = mtw_pkg::ST_ZERO;
              end else begin
                state_d = S_SCAN;
              end
            end
            mtw_pkg::CMD_REMOVE,
            mtw_pkg::CMD_KICK: begin
              state_d = S_SCAN;
            end
            mtw_pkg::CMD_START: begin
              state_d = S_FILL;
            end
            mtw_pkg::CMD_SUSPEND: begin
              watch_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rv_q && hit) begin
          state_d = S_RESP;
          case (cmd_q)
            mtw_pkg::CMD_TICK: begin
              prs_d   = 1'b1;
              ptask_d = tbl_rd.id;
              psil_d  = silence;
              fault_d = 1'b1;
            end
            mtw_pkg::CMD_ADD: begin
              tbl_wr.we_key  = 1'b1;
              tbl_wr.we_seen = 1'b1;
              tbl_wr.addr    = ridx_q;
              tbl_wr.id      = id_q;
              tbl_wr.tmo     = tmo_q;
              tbl_wr.seen    = clock_q;
            end
            mtw_pkg::CMD_KICK: begin
              tbl_wr.we_seen = 1'b1;
              tbl_wr.addr    = ridx_q;
              tbl_wr.seen    = clock_q;
            end
            default: begin
              // remove: shift the following entries up by one
              ptr_d   = mtw_pkg::CNT_W'(ridx_q) + 1'b1;
              state_d = S_MOVE;
            end
          endcase
        end else if (!rv_q && !walk_more) begin
          // Walk finished without a match.
          state_d = S_RESP;
          case (cmd_q)
            mtw_pkg::CMD_ADD: begin
              if (count_q >= mtw_pkg::CNT_W'(mtw_pkg::MAX_ENTRIES)) begin
                pst_d = mtw_pkg::ST_FULL;
              end else begin
                tbl_wr.we_key  = 1'b1;
                tbl_wr.we_seen = 1'b1;
                tbl_wr.addr    = count_q[mtw_pkg::IDX_W-1:0];
                tbl_wr.id      = id_q;
                tbl_wr.tmo     = tmo_q;
                tbl_wr.seen    = clock_q;
                count_d        = count_q + 1'b1;
              end
            end
            mtw_pkg::CMD_REMOVE,
            mtw_pkg::CMD_KICK: begin
              pst_d = mtw_pkg::ST_NOTFOUND;
            end
            default: begin
            end
          endcase
        end else if (walk_more) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          rv_d   = 1'b1;
          ridx_d = ptr_q[mtw_pkg::IDX_W-1:0];
        end
      end

      S_MOVE: begin
        // Read entry j while entry j-1 of the previous read is written back;
        // the write never touches an entry still to be read.
        if (rv_q) begin
          tbl_wr.we_key  = 1'b1;
          tbl_wr.we_seen = 1'b1;
          tbl_wr.addr    = ridx_q - 1'b1;
          tbl_wr.id      = tbl_rd.id;
          tbl_wr.tmo     = tbl_rd.tmo;
          tbl_wr.seen    = tbl_rd.seen;
        end
        if (walk_more) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          rv_d   = 1'b1;
          ridx_d = ptr_q[mtw_pkg::IDX_W-1:0];
        end else if (!rv_q) begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end
      end

      S_FILL: begin
        if (walk_more) begin
          tbl_wr.we_seen = 1'b1;
          tbl_wr.addr    = ptr_q[mtw_pkg::IDX_W-1:0];
          tbl_wr.seen    = clock_q;
          ptr_d          = ptr_q + 1'b1;
        end else begin
          watch_d = 1'b1;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        // Hand over once the output register is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= mtw_pkg::PERIOD_RESET;
      clock_q     <= '0;
      pcount_q    <= '0;
      watch_q     <= 1'b0;
      fault_q     <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      clock_q     <= clock_d;
      pcount_q    <= pcount_d;
      watch_q     <= watch_d;
      fault_q     <= fault_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    id_q    <= id_d;
    tmo_q   <= tmo_d;
    ridx_q  <= ridx_d;
    pst_q   <= pst_d;
    prs_q   <= prs_d;
    ptask_q <= ptask_d;
    psil_q  <= psil_d;
    if (out_load) begin
      status_q     <= pst_q;
      restart_q    <= prs_q;
      fault_task_q <= ptask_q;
      silence_q    <= psil_q;
      wcount_q     <= mtw_pkg::WCNT_W'(count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign restart_o       = restart_q;
  assign fault_task_o    = fault_task_q;
  assign silence_ms_o    = silence_q;
  assign watched_count_o = wcount_q;

endmodule

### sv/mtw_table.sv
// ----------------------------------------------------------------------------
// Watchdog entry table
// Two synchronous memories (id/timeout and last-seen), one write and one
// registered read port.
// ----------------------------------------------------------------------------
module mtw_table (
  input  logic                     clk_i,
  input  mtw_pkg::tbl_wr_t         wr_i,
  input  logic                     rd_en_i,
  input  logic [mtw_pkg::IDX_W-1:0] rd_addr_i,
  output mtw_pkg::tbl_rd_t         rd_o
);

  logic [mtw_pkg::ID_W+mtw_pkg::MS_W-1:0] key_mem  [mtw_pkg::MAX_ENTRIES];
  logic [mtw_pkg::MS_W-1:0]               seen_mem [mtw_pkg::MAX_ENTRIES];
  logic [mtw_pkg::ID_W+mtw_pkg::MS_W-1:0] key_q;
  logic [mtw_pkg::MS_W-1:0]               seen_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_key) begin
      key_mem[wr_i.addr] <= {wr_i.id, wr_i.tmo};
    end
    if (wr_i.we_seen) begin
      seen_mem[wr_i.addr] <= wr_i.seen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      key_q  <= key_mem[rd_addr_i];
      seen_q <= seen_mem[rd_addr_i];
    end
  end

  assign rd_o.id   = key_q[mtw_pkg::ID_W+mtw_pkg::MS_W-1:mtw_pkg::MS_W];
  assign rd_o.tmo  = key_q[mtw_pkg::MS_W-1:0];
  assign rd_o.seen = seen_q;

endmodule

### sv/mtw_checker.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [mtw_pkg::STAT_W-1:0]  status_o,
  input logic                        restart_o,
  input logic [mtw_pkg::ID_W-1:0]    fault_task_o,
  input logic [mtw_pkg::MS_W-1:0]    silence_ms_o,
  input logic [mtw_pkg::WCNT_W-1:0]  watched_count_o
);

  // A stalled result holds.
  `MTW_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 (out_valid_o && $stable(status_o) && $stable(restart_o) && $stable(silence_ms_o)), "result changed while stalled")

  // Only a tick scan raises restart, and tick status is always done.
  `MTW_ASSERT_IMPL(a_restart_status, clk_i, rst_ni, out_valid_o && restart_o, status_o == mtw_pkg::ST_DONE, "restart with non-done status")

  // Fault fields are zero without restart.
  `MTW_ASSERT_IMPL(a_fault_zero, clk_i, rst_ni, out_valid_o && !restart_o, (fault_task_o == '0) && (silence_ms_o == '0), "fault fields set without restart")

  // Table never reports more entries than it holds.
  `MTW_ASSERT(a_count_max, clk_i, rst_ni, !out_valid_o || (watched_count_o <= mtw_pkg::WCNT_W'(mtw_pkg::MAX_ENTRIES)), "watched count above table size")

endmodule

bind multi_task_watchdog mtw_checker u_mtw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .restart_o       (restart_o),
  .fault_task_o    (fault_task_o),
  .silence_ms_o    (silence_ms_o),
  .watched_count_o (watched_count_o)
);

### dv/wdog_check_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog scoreboard package
// Task-table predictor and in-order result checker for the watchdog bench.
// ----------------------------------------------------------------------------
package wdog_check_pkg;
  import mtw_pkg::*;

  // Command codes the block treats as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              restart;
    logic [ID_W-1:0]   fault_task;
    logic [MS_W-1:0]   silence;
    logic [WCNT_W-1:0] wcount;
  } wdog_resp_t;

  class task_table_board;
    // predicted block state
    logic [PER_W-1:0] period;
    logic [MS_W-1:0]  clock_ms;
    logic [PER_W-1:0] phase_cnt;
    bit               watching;
    bit               fault_seen;
    int               n_entries;
    logic [ID_W-1:0]  ids   [MAX_ENTRIES];
    logic [MS_W-1:0]  tmos  [MAX_ENTRIES];
    logic [MS_W-1:0]  seen  [MAX_ENTRIES];

    wdog_resp_t due_q[$];

    int errors;
    int n_cmds;
    int n_results;
    int n_scans;
    int n_restarts;
    int n_full;
    int n_notfound;

    function new();
      period     = PERIOD_RESET;
      clock_ms   = '0;
      phase_cnt  = '0;
      watching   = 1'b0;
      fault_seen = 1'b0;
      n_entries  = 0;
    endfunction

    function void set_period(logic [PER_W-1:0] p);
      period = p;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < n_entries; i++)
        if (ids[i] == id) return i;
      return -1;
    endfunction

    // Advance the table by one accepted command and queue its response.
    function void take_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [MS_W-1:0] tmo);
      wdog_resp_t r;
      int         slot;
      logic [MS_W-1:0] s;
      r = '{status: ST_DONE, restart: 1'b0, fault_task: '0, silence: '0, wcount: '0};
      n_cmds++;
      case (cmd)
        CMD_TICK: begin
          clock_ms  = clock_ms + 1'b1;
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= period) begin
            phase_cnt = '0;
            if (watching && !fault_seen) begin
              n_scans++;
              for (int i = 0; i < n_entries && !r.restart; i++) begin
                s = clock_ms - seen[i];
                if (s > tmos[i]) begin
                  r.restart    = 1'b1;
                  r.fault_task = ids[i];
                  r.silence    = s;
                  fault_seen   = 1'b1;
                  n_restarts++;
                end
              end
            end
          end
        end
        CMD_ADD: begin
          if (tmo == '0) begin
            r.status = ST_ZERO;
          end else begin
            slot = find_slot(id);
            if (slot >= 0) begin
              tmos[slot] = tmo;
              seen[slot] = clock_ms;
            end else if (n_entries >= MAX_ENTRIES) begin
              r.status = ST_FULL;
              n_full++;
            end else begin
              ids[n_entries]  = id;
              tmos[n_entries] = tmo;
              seen[n_entries] = clock_ms;
              n_entries++;
            end
          end
        end
        CMD_REMOVE: begin
          slot = find_slot(id);
          if (slot < 0) begin
            r.status = ST_NOTFOUND;
            n_notfound++;
          end else begin
            for (int i = slot; i < n_entries - 1; i++) begin
              ids[i]  = ids[i+1];
              tmos[i] = tmos[i+1];
              seen[i] = seen[i+1];
            end
            n_entries--;
          end
        end
        CMD_KICK: begin
          slot = find_slot(id);
          if (slot < 0) begin
            r.status = ST_NOTFOUND;
            n_notfound++;
          end else begin
            seen[slot] = clock_ms;
          end
        end
        CMD_START: begin
          for (int i = 0; i < n_entries; i++) seen[i] = clock_ms;
          watching = 1'b1;
        end
        CMD_SUSPEND: watching = 1'b0;
        default: ;
      endcase
      r.wcount = n_entries[WCNT_W-1:0];
      due_q = {due_q, r};
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_response(logic [STAT_W-1:0] status, logic restart,
                        logic [ID_W-1:0] fault_task, logic [MS_W-1:0] silence,
                        logic [WCNT_W-1:0] wcount);
      wdog_resp_t e;
      if (due_q.size() == 0) begin
        report_mismatch("response with no command outstanding");
        return;
      end
      e = due_q.pop_front();
      n_results++;
      if (status !== e.status)
        report_mismatch($sformatf("resp %0d status %0d, want %0d", n_results, status, e.status));
      if (restart !== e.restart)
        report_mismatch($sformatf("resp %0d restart %0d, want %0d", n_results, restart,
                                  e.restart));
      if (fault_task !== e.fault_task)
        report_mismatch($sformatf("resp %0d fault_task %0h, want %0h", n_results, fault_task,
                                  e.fault_task));
      if (silence !== e.silence)
        report_mismatch($sformatf("resp %0d silence %0d, want %0d", n_results, silence,
                                  e.silence));
      if (wcount !== e.wcount)
        report_mismatch($sformatf("resp %0d watched_count %0d, want %0d", n_results, wcount,
                                  e.wcount));
    endtask
  endclass

endpackage

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog testbench
// Drives table commands and period writes through valid/ready channels with
// random idling on both sides; every response is checked field by field
// against a task-table predictor held in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import mtw_pkg::*;
  import wdog_check_pkg::*;

  // No-progress limit: well above the longest command walk plus the largest
  // sender gap and receiver stall.
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int POOL_SIZE   = 24;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;

  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [PER_W-1:0]    cfg_period = '0;

  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd        = CMD_TICK;
  logic [ID_W-1:0]     task_id    = '0;
  logic [MS_W-1:0]     timeout_ms = '0;

  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [STAT_W-1:0]   status;
  logic                restart;
  logic [ID_W-1:0]     fault_task;
  logic [MS_W-1:0]     silence_ms;
  logic [WCNT_W-1:0]   watched_count;

  task_table_board     sb;
  bit                  quiet = 1'b0;     // both sides run back to back
  int                  stall_left = 0;
  int                  stall_draw;
  int                  idle_cycles = 0;
  logic [ID_W-1:0]     id_pool[POOL_SIZE];

  always #10 clk_i = ~clk_i;

  multi_task_watchdog uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .check_period_ms_i (cfg_period),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .cmd_i             (cmd),
    .task_id_i         (task_id),
    .timeout_ms_i      (timeout_ms),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .restart_o         (restart),
    .fault_task_o      (fault_task),
    .silence_ms_o      (silence_ms),
    .watched_count_o   (watched_count)
  );

  // --------------------------------------------------------------------------
  // Response side: check each transaction, then draw a random stall, none when
  // quiet, before taking the next one. Outputs are read at the edge, before the
  // block's own updates land, so the check sees the accepted values.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_response(status, restart, fault_task, silence_ms, watched_count);
      stall_draw = quiet ? 0 : $urandom_range(0, 8);
      out_ready  <= (stall_draw == 0);
      stall_left <= stall_draw;
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Watchdog: ends the run if no channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // One command transaction. Valid is only dropped when a gap is drawn, so a
  // back-to-back command keeps it high across the edge.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                          input logic [MS_W-1:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    task_id    <= id;
    timeout_ms <= t;
    do @(posedge clk_i); while (!in_ready);
    sb.take_command(c, id, t);
  endtask

  // Hold off new commands until every queued response has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Period writes happen only with the block drained; every command gives a
  // response, so an empty queue means the block is idle.
  task automatic write_period(input logic [PER_W-1:0] p);
    wait_idle();
    cfg_valid  <= 1'b1;
    cfg_period <= p;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_period(p);
  endtask

  // Long timeouts keep the table healthy through the non-fault phases.
  function automatic logic [MS_W-1:0] long_tmo();
    logic [MS_W-1:0] t;
    t = $urandom;
    return (t < 32'd5000) ? t + 32'd5000 : t;
  endfunction

  function automatic logic [ID_W-1:0] known_id();
    if (sb.n_entries == 0) return id_pool[$urandom_range(0, POOL_SIZE-1)];
    return sb.ids[$urandom_range(0, sb.n_entries-1)];
  endfunction

  // Mostly ids that hit the table or the small pool, some fully random.
  function automatic logic [ID_W-1:0] any_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return known_id();
    if (r < 8) return id_pool[$urandom_range(0, POOL_SIZE-1)];
    return ID_W'($urandom_range(0, 255));
  endfunction

  // Corner cases: zero timeouts, refresh of a known id, filling to full,
  // head removal with compaction, not-found, spare opcodes.
  task automatic run_directed();
    send_cmd(CMD_ADD, 8'h00, 32'd0);              // zero timeout, empty table
    send_cmd(CMD_ADD, 8'h00, 32'd1);
    send_cmd(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD, 8'h00, 32'd5);              // known id: refresh
    send_cmd(CMD_ADD, 8'h00, 32'd0);              // zero check wins over lookup
    send_cmd(CMD_REMOVE, 8'h5A, $urandom);        // unknown id
    for (int i = 1; i <= MAX_ENTRIES - 2; i++)
      send_cmd(CMD_ADD, 8'(i * 16 + 1), long_tmo());
    send_cmd(CMD_ADD, 8'h5A, 32'd77);             // table full
    send_cmd(CMD_REMOVE, 8'h00, $urandom);        // head out, rest shift up
    send_cmd(CMD_KICK, 8'hFF, $urandom);
    send_cmd(CMD_START, 8'h00, $urandom);
    send_cmd(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_SUSPEND, 8'h00, 32'd0);
    send_cmd(CMD_SPARE_LO, ID_W'($urandom), $urandom);
    send_cmd(CMD_SPARE_HI, ID_W'($urandom), $urandom);
  endtask

  // Random traffic. Kicks and removes mostly target live entries so the
  // table churns; short_tmo switches to timeouts a scan can actually trip.
  task automatic run_random(input int n_items, input bit short_tmo);
    int              pick;
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0]  id;
    logic [MS_W-1:0]  t;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) wait_idle();
      pick = $urandom_range(0, 99);
      id   = any_id();
      t    = $urandom;
      if (pick < 34) begin
        c = CMD_TICK;
      end else if (pick < 52) begin
        c = CMD_ADD;
        if ($urandom_range(0, 11) == 0) t = '0;
        else t = short_tmo ? MS_W'($urandom_range(1, 24)) : long_tmo();
      end else if (pick < 64) begin
        c = CMD_REMOVE;
        if ($urandom_range(0, 4) != 0) id = known_id();
      end else if (pick < 84) begin
        c = CMD_KICK;
        if ($urandom_range(0, 6) != 0) id = known_id();
      end else if (pick < 90) begin
        c = CMD_START;
      end else if (pick < 95) begin
        c = CMD_SUSPEND;
      end else begin
        c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      end
      send_cmd(c, id, t);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: directed at the reset period, then random phases at the period
  // extremes and random values, ending with short timeouts so a scan latches
  // a fault and the table keeps working behind it.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 255));
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    run_directed();

    write_period(16'hFFFF);                       // scans never due
    run_random(200, 1'b0);
    write_period(16'd0);                          // behaves as one: every tick
    run_random(150, 1'b0);
    write_period(16'd1);
    run_random(150, 1'b0);
    write_period(PER_W'($urandom_range(2, 40)));
    run_random(200, 1'b0);
    write_period(PER_W'($urandom_range(2, 6)));
    send_cmd(CMD_START, 8'h00, $urandom);
    run_random(250, 1'b1);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("responses still outstanding at end");

    $display("Summary: %0d commands, %0d responses, %0d scans, %0d restart(s)",
             sb.n_cmds, sb.n_results, sb.n_scans, sb.n_restarts);
    $display("Summary: periods 1000/65535/0/1/random, %0d full adds, %0d not-found",
             sb.n_full, sb.n_notfound);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/mtw_pkg.sv
sv/mtw_table.sv
sv/multi_task_watchdog.sv
sv/mtw_checker.sv
dv/wdog_check_pkg.sv
dv/tb_top.sv
